/* rtl/core/dlra_pkg.sv */
// Shared types, codes, defaults and saturation for the display layout resize block.
package dlra_pkg;

    localparam int DEFAULT_MAX_DISPLAYS = 8;
    localparam int REG_INDEX_W = 1;
    localparam int REG_DATA_W = 4;

    localparam logic [REG_INDEX_W-1:0] REG_DISPLAY_COUNT = 1'b0;
    localparam logic [REG_INDEX_W-1:0] REG_PRIMARY_DISPLAY = 1'b1;

    localparam logic [3:0] COUNT_RESET = 4'd1;
    localparam logic [2:0] PRIMARY_RESET = 3'd0;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RESIZE = 1'b1;

    typedef enum logic [1:0] {
        DIR_XPOS,
        DIR_XNEG,
        DIR_YPOS,
        DIR_YNEG
    } dir_t;

    typedef struct packed {
        logic               command;
        logic [2:0]         display_index;
        logic signed [15:0] rect_left;
        logic signed [15:0] rect_top;
        logic signed [15:0] rect_right;
        logic signed [15:0] rect_bottom;
        logic [14:0]        new_width;
        logic [14:0]        new_height;
    } req_t;

    typedef struct packed {
        logic [2:0]         out_index;
        logic signed [15:0] out_left;
        logic signed [15:0] out_top;
        logic signed [15:0] out_right;
        logic signed [15:0] out_bottom;
        logic               last;
    } res_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
    } box_t;

    typedef struct packed {
        logic load_we;
        logic take;
        logic copy_we;
        logic resize_sel;
        logic pivot_load;
        logic adj_we;
        logic out_we;
        logic last;
        dir_t dir;
    } ctl_cmd_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -18'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/dlra_dp.sv */
// Datapath: layout memories, neighbour compare, shift and saturation, result register.
module dlra_dp
    import dlra_pkg::*;
#(
    parameter int MAX_DISPLAYS = DEFAULT_MAX_DISPLAYS,
    localparam int IW = (MAX_DISPLAYS > 1) ? $clog2(MAX_DISPLAYS) : 1
)
(
    input  logic          clk,
    input  req_t          request,
    input  ctl_cmd_t      cmd,
    input  logic [IW-1:0] orig_waddr,
    input  logic [IW-1:0] orig_raddr,
    input  logic [IW-1:0] work_waddr,
    input  logic [IW-1:0] work_raddr_a,
    input  logic [IW-1:0] work_raddr_b,
    output logic          hit,
    output res_t          result
);

    box_t orig_mem [MAX_DISPLAYS];
    box_t work_mem [MAX_DISPLAYS];

    box_t        orig_rd_reg;
    box_t        wa_reg;
    box_t        wb_reg;
    box_t        pivot_reg;
    logic [14:0] width_reg;
    logic [14:0] height_reg;
    res_t        result_reg;

    box_t               load_box;
    box_t               copy_box;
    box_t               shift_box;
    box_t               orig_wdata;
    box_t               work_wdata;
    logic               orig_we;
    logic               work_we;
    logic signed [16:0] delta;
    logic               shift_ok;
    logic signed [17:0] sum_lo;
    logic signed [17:0] sum_hi;
    logic signed [17:0] sum_r;
    logic signed [17:0] sum_b;

    always_comb
    begin
        load_box.left   = request.rect_left;
        load_box.top    = request.rect_top;
        load_box.right  = request.rect_right;
        load_box.bottom = request.rect_bottom;
    end

    always_comb
    begin
        sum_r = 18'(orig_rd_reg.left) + 18'(width_reg);
        sum_b = 18'(orig_rd_reg.top) + 18'(height_reg);
        copy_box = orig_rd_reg;
        if (cmd.resize_sel)
        begin
            copy_box.right  = sat16(sum_r);
            copy_box.bottom = sat16(sum_b);
        end
    end

    always_comb
    begin
        case (cmd.dir)
            DIR_XPOS: hit = (pivot_reg.right == orig_rd_reg.left);
            DIR_XNEG: hit = (pivot_reg.left == orig_rd_reg.right);
            DIR_YPOS: hit = (pivot_reg.bottom == orig_rd_reg.top);
            DIR_YNEG: hit = (pivot_reg.top == orig_rd_reg.bottom);
            default:  hit = 1'b0;
        endcase
    end

    always_comb
    begin
        case (cmd.dir)
            DIR_XPOS: delta = 17'(wa_reg.right) - 17'(wb_reg.left);
            DIR_XNEG: delta = 17'(wa_reg.left) - 17'(wb_reg.right);
            DIR_YPOS: delta = 17'(wa_reg.bottom) - 17'(wb_reg.top);
            DIR_YNEG: delta = 17'(wa_reg.top) - 17'(wb_reg.bottom);
            default:  delta = '0;
        endcase
        shift_box = wb_reg;
        case (cmd.dir) inside
            DIR_XPOS, DIR_XNEG:
            begin
                sum_lo = 18'(wb_reg.left) + 18'(delta);
                sum_hi = 18'(wb_reg.right) + 18'(delta);
                shift_box.left  = sat16(sum_lo);
                shift_box.right = sat16(sum_hi);
            end
            default:
            begin
                sum_lo = 18'(wb_reg.top) + 18'(delta);
                sum_hi = 18'(wb_reg.bottom) + 18'(delta);
                shift_box.top    = sat16(sum_lo);
                shift_box.bottom = sat16(sum_hi);
            end
        endcase
        case (cmd.dir) inside
            DIR_XPOS, DIR_YPOS: shift_ok = !delta[16] && (delta != '0);
            default:            shift_ok = delta[16];
        endcase
    end

    assign orig_we    = cmd.load_we | cmd.out_we;
    assign orig_wdata = cmd.out_we ? wa_reg : load_box;
    assign work_we    = cmd.copy_we | (cmd.adj_we & shift_ok);
    assign work_wdata = cmd.copy_we ? copy_box : shift_box;

    always_ff @(posedge clk)
    begin
        if (orig_we)
        begin
            orig_mem[orig_waddr] <= orig_wdata;
        end
        orig_rd_reg <= orig_mem[orig_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
        begin
            work_mem[work_waddr] <= work_wdata;
        end
        wa_reg <= work_mem[work_raddr_a];
        wb_reg <= work_mem[work_raddr_b];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            width_reg  <= request.new_width;
            height_reg <= request.new_height;
        end
        if (cmd.pivot_load)
        begin
            pivot_reg <= orig_rd_reg;
        end
        if (cmd.out_we)
        begin
            result_reg.out_index  <= 3'(orig_waddr);
            result_reg.out_left   <= wa_reg.left;
            result_reg.out_top    <= wa_reg.top;
            result_reg.out_right  <= wa_reg.right;
            result_reg.out_bottom <= wa_reg.bottom;
            result_reg.last       <= cmd.last;
        end
    end

    assign result = result_reg;

endmodule

/* rtl/core/dlra_ctrl.sv */
// Controller: configuration registers, sequencing of copy, four passes and write-back.
module dlra_ctrl
    import dlra_pkg::*;
#(
    parameter int MAX_DISPLAYS = DEFAULT_MAX_DISPLAYS,
    localparam int IW = (MAX_DISPLAYS > 1) ? $clog2(MAX_DISPLAYS) : 1,
    localparam int CW = $clog2(MAX_DISPLAYS + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  req_t                   request,
    input  logic                   wr_en,
    input  logic [REG_INDEX_W-1:0] wr_index,
    input  logic [REG_DATA_W-1:0]  wr_data,
    input  logic                   hit,
    output logic                   busy,
    output logic                   result_valid,
    output ctl_cmd_t               cmd,
    output logic [IW-1:0]          orig_waddr,
    output logic [IW-1:0]          orig_raddr,
    output logic [IW-1:0]          work_waddr,
    output logic [IW-1:0]          work_raddr_a,
    output logic [IW-1:0]          work_raddr_b
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_COPY_RD,
        S_COPY_WR,
        S_PIV_RD,
        S_PIV_LD,
        S_SCAN,
        S_ADJ_RD,
        S_ADJ_WR,
        S_OUT_RD,
        S_OUT_WR
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    dir_t          dir_reg, dir_next;
    logic [2:0]    idx_reg, idx_next;
    logic [3:0]    count_reg, count_next;
    logic [2:0]    primary_reg, primary_next;
    logic          valid_reg, valid_next;
    logic          adj_reg, adj_next;

    logic [CW-1:0] n_eff;
    logic          accept;
    logic          resize_ok;
    logic          k_last;
    logic          i_last;
    logic          j_last;
    logic          j_primary;

    assign n_eff = (int'(count_reg) > MAX_DISPLAYS) ? CW'(MAX_DISPLAYS) : CW'(count_reg);
    assign accept = start && (state_reg == S_IDLE);
    assign resize_ok = (n_eff != '0) && (int'(request.display_index) < int'(n_eff));
    assign k_last = ((CW'(k_reg) + CW'(1)) == n_eff);
    assign i_last = ((CW'(i_reg) + CW'(1)) == n_eff);
    assign j_last = ((CW'(j_reg) + CW'(1)) == n_eff);
    assign j_primary = (int'(j_reg) == int'(primary_reg));

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        dir_next     = dir_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        primary_next = primary_reg;
        valid_next   = (state_reg == S_OUT_WR);
        adj_next     = (state_reg == S_ADJ_RD);

        if (wr_en)
        begin
            unique case (wr_index)
                REG_DISPLAY_COUNT:   count_next = wr_data;
                REG_PRIMARY_DISPLAY: primary_next = wr_data[2:0];
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (request.command == CMD_RESIZE) && resize_ok)
                begin
                    idx_next   = request.display_index;
                    k_next     = '0;
                    state_next = S_COPY_RD;
                end
            end
            S_COPY_RD:
            begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                if (k_last)
                begin
                    i_next     = '0;
                    dir_next   = DIR_XPOS;
                    state_next = S_PIV_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_COPY_RD;
                end
            end
            S_PIV_RD:
            begin
                state_next = S_PIV_LD;
            end
            S_PIV_LD:
            begin
                j_next     = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (hit && !j_primary)
                begin
                    state_next = S_ADJ_RD;
                end
                else if (hit || j_last)
                begin
                    state_next = S_ADJ_WR;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_ADJ_RD:
            begin
                state_next = S_ADJ_WR;
            end
            S_ADJ_WR:
            begin
                if (!i_last)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_PIV_RD;
                end
                else if (dir_reg == DIR_YNEG)
                begin
                    k_next     = '0;
                    state_next = S_OUT_RD;
                end
                else
                begin
                    i_next     = '0;
                    dir_next   = dir_t'(dir_reg + 2'd1);
                    state_next = S_PIV_RD;
                end
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_WR;
            end
            S_OUT_WR:
            begin
                if (k_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            dir_reg     <= DIR_XPOS;
            idx_reg     <= '0;
            count_reg   <= COUNT_RESET;
            primary_reg <= PRIMARY_RESET;
            valid_reg   <= 1'b0;
            adj_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            dir_reg     <= dir_next;
            idx_reg     <= idx_next;
            count_reg   <= count_next;
            primary_reg <= primary_next;
            valid_reg   <= valid_next;
            adj_reg     <= adj_next;
        end
    end

    // A skipped neighbour passes through the write state with the write held off.
    always_comb
    begin
        cmd.load_we    = accept && (request.command == CMD_LOAD)
                         && (int'(request.display_index) < MAX_DISPLAYS);
        cmd.take       = accept;
        cmd.copy_we    = (state_reg == S_COPY_WR);
        cmd.resize_sel = (int'(k_reg) == int'(idx_reg));
        cmd.pivot_load = (state_reg == S_PIV_LD);
        cmd.adj_we     = (state_reg == S_ADJ_WR) && adj_reg;
        cmd.out_we     = (state_reg == S_OUT_WR);
        cmd.last       = k_last;
        cmd.dir        = dir_reg;
    end

    always_comb
    begin
        orig_waddr = (state_reg == S_IDLE) ? IW'(request.display_index) : k_reg;
        case (state_reg)
            S_PIV_RD: orig_raddr = i_reg;
            S_PIV_LD: orig_raddr = '0;
            S_SCAN:   orig_raddr = j_reg + 1'b1;
            default:  orig_raddr = k_reg;
        endcase
        work_waddr   = (state_reg == S_ADJ_WR) ? j_reg : k_reg;
        work_raddr_a = (state_reg == S_ADJ_RD) ? i_reg : k_reg;
        work_raddr_b = j_reg;
    end

    assign busy = (state_reg != S_IDLE);
    assign result_valid = valid_reg;

endmodule

/* rtl/core/display_layout_resize_adjust.sv */
// Top level of the display layout resize and adjust block.
// A load request writes its slot and returns nothing. A resize request for a
// slot below the display count returns one result per display, in slot order,
// each shown for one cycle with result_valid; the receiver cannot stall, so
// results must be taken as they appear. Each of the four passes of a resize
// scans the original layout through its single read port, one rectangle per
// cycle, for every rectangle, and the copy and write-back sweeps read and then
// write each slot in turn.
// A new request may be issued in the cycle the final result is shown.
module display_layout_resize_adjust
    import dlra_pkg::*;
#(
    parameter int MAX_DISPLAYS = DEFAULT_MAX_DISPLAYS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  req_t                   request,
    output logic                   result_valid,
    output res_t                   result,
    input  logic                   wr_en,
    input  logic [REG_INDEX_W-1:0] wr_index,
    input  logic [REG_DATA_W-1:0]  wr_data
);

    localparam int IW = (MAX_DISPLAYS > 1) ? $clog2(MAX_DISPLAYS) : 1;

    ctl_cmd_t      cmd;
    logic          hit;
    logic [IW-1:0] orig_waddr;
    logic [IW-1:0] orig_raddr;
    logic [IW-1:0] work_waddr;
    logic [IW-1:0] work_raddr_a;
    logic [IW-1:0] work_raddr_b;

    dlra_ctrl #(
        .MAX_DISPLAYS (MAX_DISPLAYS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .hit          (hit),
        .busy         (busy),
        .result_valid (result_valid),
        .cmd          (cmd),
        .orig_waddr   (orig_waddr),
        .orig_raddr   (orig_raddr),
        .work_waddr   (work_waddr),
        .work_raddr_a (work_raddr_a),
        .work_raddr_b (work_raddr_b)
    );

    dlra_dp #(
        .MAX_DISPLAYS (MAX_DISPLAYS)
    ) u_dp (
        .clk          (clk),
        .request      (request),
        .cmd          (cmd),
        .orig_waddr   (orig_waddr),
        .orig_raddr   (orig_raddr),
        .work_waddr   (work_waddr),
        .work_raddr_a (work_raddr_a),
        .work_raddr_b (work_raddr_b),
        .hit          (hit),
        .result       (result)
    );

endmodule

/* tb/display_layout_resize_adjust_tb.sv */
// Self-checking testbench for the display layout resize and adjust block.
module display_layout_resize_adjust_tb;
    import dlra_pkg::*;

    localparam int MAX_SLOTS = DEFAULT_MAX_DISPLAYS;
    localparam int SETTLE_CYCLES = 480;
    localparam int CYCLE_LIMIT = 1000000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    req_t                   request = '0;
    logic                   result_valid;
    res_t                   result;
    logic                   wr_en = 1'b0;
    logic [REG_INDEX_W-1:0] wr_index = '0;
    logic [REG_DATA_W-1:0]  wr_data = '0;

    box_t       stored_layout [MAX_SLOTS];
    box_t       scratch_layout [MAX_SLOTS];
    logic [3:0] cfg_count = COUNT_RESET;
    logic [2:0] cfg_primary = PRIMARY_RESET;

    req_t pending_requests [$];
    res_t expected_rects [$];

    int idle_pct = 28;
    int queued_total = 0;
    int loads_sent = 0;
    int resizes_sent = 0;
    int results_checked = 0;
    int settings_applied = 0;
    int error_count = 0;
    int cycle_count = 0;

    display_layout_resize_adjust dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic flag_error(input string what);
        if (error_count < 40)
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
        error_count++;
    endtask

    function automatic logic signed [15:0] clamp_coord(input int v);
        int c;
        c = (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
        return 16'(c);
    endfunction

    function automatic int live_slots();
        return (cfg_count > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_count);
    endfunction

    // lowest slot that touched slot i in direction d before the resize
    function automatic int touching_slot(input int n, input int i, input dir_t d);
        logic hit;
        for (int j = 0; j < n; j++)
        begin
            case (d)
                DIR_XPOS: hit = stored_layout[i].right == stored_layout[j].left;
                DIR_XNEG: hit = stored_layout[i].left == stored_layout[j].right;
                DIR_YPOS: hit = stored_layout[i].bottom == stored_layout[j].top;
                default:  hit = stored_layout[i].top == stored_layout[j].bottom;
            endcase
            if (hit)
            begin
                return j;
            end
        end
        return -1;
    endfunction

    function automatic void shift_pass(input int n, input dir_t d);
        int  j;
        int  delta;
        bit  moves;
        for (int i = 0; i < n; i++)
        begin
            j = touching_slot(n, i, d);
            if (j >= 0 && j != int'(cfg_primary))
            begin
                case (d)
                    DIR_XPOS: delta = int'(scratch_layout[i].right) - int'(scratch_layout[j].left);
                    DIR_XNEG: delta = int'(scratch_layout[i].left) - int'(scratch_layout[j].right);
                    DIR_YPOS: delta = int'(scratch_layout[i].bottom) - int'(scratch_layout[j].top);
                    default:  delta = int'(scratch_layout[i].top) - int'(scratch_layout[j].bottom);
                endcase
                moves = (d == DIR_XPOS || d == DIR_YPOS) ? (delta > 0) : (delta < 0);
                if (moves && (d == DIR_XPOS || d == DIR_XNEG))
                begin
                    scratch_layout[j].left = clamp_coord(int'(scratch_layout[j].left) + delta);
                    scratch_layout[j].right = clamp_coord(int'(scratch_layout[j].right) + delta);
                end
                else if (moves)
                begin
                    scratch_layout[j].top = clamp_coord(int'(scratch_layout[j].top) + delta);
                    scratch_layout[j].bottom = clamp_coord(int'(scratch_layout[j].bottom) + delta);
                end
            end
        end
    endfunction

    function automatic void predict_layout(input req_t rq);
        int   n;
        int   s;
        res_t rect;
        s = int'(rq.display_index);
        if (rq.command == CMD_LOAD)
        begin
            stored_layout[s] = '{rq.rect_left, rq.rect_top, rq.rect_right, rq.rect_bottom};
        end
        else
        begin
            n = live_slots();
            if (n != 0 && s < n)
            begin
                scratch_layout = stored_layout;
                scratch_layout[s].right =
                    clamp_coord(int'(scratch_layout[s].left) + int'(rq.new_width));
                scratch_layout[s].bottom =
                    clamp_coord(int'(scratch_layout[s].top) + int'(rq.new_height));
                for (int p = 0; p < 4; p++)
                begin
                    shift_pass(n, dir_t'(p));
                end
                for (int k = 0; k < n; k++)
                begin
                    rect.out_index = 3'(k);
                    rect.out_left = scratch_layout[k].left;
                    rect.out_top = scratch_layout[k].top;
                    rect.out_right = scratch_layout[k].right;
                    rect.out_bottom = scratch_layout[k].bottom;
                    rect.last = (k == n - 1);
                    expected_rects.push_back(rect);
                    stored_layout[k] = scratch_layout[k];
                end
            end
        end
    endfunction

    function automatic req_t noise_request();
        req_t rq;
        rq.command = 1'($urandom);
        rq.display_index = 3'($urandom);
        rq.rect_left = 16'($urandom);
        rq.rect_top = 16'($urandom);
        rq.rect_right = 16'($urandom);
        rq.rect_bottom = 16'($urandom);
        rq.new_width = 15'($urandom);
        rq.new_height = 15'($urandom);
        return rq;
    endfunction

    function automatic void queue_load(input int slot, input int l, input int t,
                                       input int r, input int b);
        req_t rq;
        rq = noise_request();
        rq.command = CMD_LOAD;
        rq.display_index = 3'(slot);
        rq.rect_left = clamp_coord(l);
        rq.rect_top = clamp_coord(t);
        rq.rect_right = clamp_coord(r);
        rq.rect_bottom = clamp_coord(b);
        pending_requests.push_back(rq);
        queued_total++;
    endfunction

    function automatic void queue_resize(input int slot, input int w, input int h);
        req_t rq;
        rq = noise_request();
        rq.command = CMD_RESIZE;
        rq.display_index = 3'(slot);
        rq.new_width = 15'(w);
        rq.new_height = 15'(h);
        pending_requests.push_back(rq);
        queued_total++;
    endfunction

    function automatic int pick_extent();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 32767;
            2, 3: return $urandom_range(0, 32767);
            default: return $urandom_range(0, 2500);
        endcase
    endfunction

    // one layout (row, column, grid, row near the edges, or noise) then a few resizes
    function automatic void queue_scenario(input int n_live);
        int style, x0, y0, w, h, cw, ch, j, tmp, loads, reps, slot;
        int pos [8];
        int bl [8];
        int bt [8];
        int br [8];
        int bb [8];
        style = $urandom_range(0, 4);
        x0 = $urandom_range(0, 8000) - 4000;
        y0 = $urandom_range(0, 8000) - 4000;
        if (style == 3)
        begin
            x0 = 32767 - $urandom_range(0, 5000);
            y0 = $urandom_range(0, 3000) - 32768;
        end
        cw = $urandom_range(0, 1600);
        ch = $urandom_range(0, 1200);
        for (int k = 0; k < 8; k++)
        begin
            pos[k] = k;
            w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 1600);
            h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 1200);
            case (style)
                0, 3:
                begin
                    bl[k] = x0; bt[k] = y0; br[k] = x0 + w; bb[k] = y0 + h;
                    x0 = x0 + w;
                end
                1:
                begin
                    bl[k] = x0; bt[k] = y0; br[k] = x0 + w; bb[k] = y0 + h;
                    y0 = y0 + h;
                end
                2:
                begin
                    bl[k] = x0 + (k % 4) * cw; br[k] = bl[k] + cw;
                    bt[k] = y0 + (k / 4) * ch; bb[k] = bt[k] + ch;
                end
                default:
                begin
                    bl[k] = $urandom_range(0, 65535) - 32768;
                    bt[k] = $urandom_range(0, 65535) - 32768;
                    br[k] = $urandom_range(0, 65535) - 32768;
                    bb[k] = $urandom_range(0, 65535) - 32768;
                    if (k > 0 && $urandom_range(0, 1) == 0)
                    begin
                        bl[k] = br[k-1];
                    end
                end
            endcase
        end
        for (int k = 7; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            tmp = pos[k]; pos[k] = pos[j]; pos[j] = tmp;
        end
        loads = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 8;
        for (int k = 0; k < loads; k++)
        begin
            queue_load(pos[k], bl[k], bt[k], br[k], bb[k]);
        end
        reps = $urandom_range(1, 4);
        for (int k = 0; k < reps; k++)
        begin
            slot = (n_live > 0 && $urandom_range(0, 9) != 0) ?
                   $urandom_range(0, n_live - 1) : $urandom_range(0, 7);
            queue_resize(slot, pick_extent(), pick_extent());
        end
    endfunction

    task automatic drain_results();
        while (pending_requests.size() != 0 || start || expected_rects.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic settle_block();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy || expected_rects.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_register(input logic [REG_INDEX_W-1:0] idx,
                                  input logic [REG_DATA_W-1:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_DISPLAY_COUNT)
        begin
            cfg_count = val;
        end
        else
        begin
            cfg_primary = val[2:0];
        end
    endtask

    task automatic apply_settings(input logic [3:0] count, input logic [2:0] primary);
        write_register(REG_DISPLAY_COUNT, REG_DATA_W'(count));
        write_register(REG_PRIMARY_DISPLAY, REG_DATA_W'(primary));
        settings_applied++;
    endtask

    // request driver: hold while busy, otherwise issue or idle
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_layout(request);
                if (request.command == CMD_LOAD)
                begin
                    loads_sent++;
                end
                else
                begin
                    resizes_sent++;
                end
            end
            if (!(start && busy))
            begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    start <= 1'b1;
                    request <= pending_requests.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && result_valid)
        begin
            if (expected_rects.size() == 0)
            begin
                flag_error($sformatf("rectangle %0d with no resize outstanding",
                                     result.out_index));
            end
            else
            begin
                want = expected_rects.pop_front();
                results_checked++;
                if (result.out_index !== want.out_index)
                    flag_error($sformatf("index got %0d want %0d",
                                         result.out_index, want.out_index));
                if (result.out_left !== want.out_left)
                    flag_error($sformatf("slot %0d left got %0d want %0d",
                                         want.out_index, result.out_left, want.out_left));
                if (result.out_top !== want.out_top)
                    flag_error($sformatf("slot %0d top got %0d want %0d",
                                         want.out_index, result.out_top, want.out_top));
                if (result.out_right !== want.out_right)
                    flag_error($sformatf("slot %0d right got %0d want %0d",
                                         want.out_index, result.out_right, want.out_right));
                if (result.out_bottom !== want.out_bottom)
                    flag_error($sformatf("slot %0d bottom got %0d want %0d",
                                         want.out_index, result.out_bottom, want.out_bottom));
                if (result.last !== want.last)
                    flag_error($sformatf("slot %0d last got %0b want %0b",
                                         want.out_index, result.last, want.last));
            end
        end
    end

    initial
    begin
        int settings_count [9];
        int settings_primary [9];
        int goal;
        settings_count = '{8, 8, 15, 5, 8, 2, 12, 8, 1};
        settings_primary = '{0, 3, 7, 2, 7, 1, 5, 6, 0};
        for (int k = 0; k < MAX_SLOTS; k++)
        begin
            stored_layout[k] = '0;
            scratch_layout[k] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        settle_block();

        // row of touching displays, a zero-width one, and a full-range strip below
        apply_settings(4'd8, 3'd0);
        for (int k = 0; k < 6; k++)
        begin
            queue_load(k, k * 100, 0, k * 100 + 100, 100);
        end
        queue_load(6, 600, 0, 600, 100);
        queue_load(7, -32768, 100, 32767, 32767);
        queue_resize(0, 250, 180);
        queue_resize(6, 0, 0);
        queue_resize(3, 32767, 32767);
        queue_resize(7, 0, 0);
        queue_resize(5, 32767, 0);
        settle_block();

        // primary outside the layout, a resize past the count
        apply_settings(4'd3, 3'd7);
        queue_resize(1, 100, 100);
        queue_resize(5, 20, 20);
        queue_load(2, 32767, -32768, -32768, 32767);
        queue_resize(2, 0, 32767);
        settle_block();

        apply_settings(4'd0, 3'd2);
        queue_resize(0, 10, 10);
        settle_block();

        apply_settings(4'd15, 3'd7);
        queue_resize(7, 40, 40);
        queue_resize(0, 0, 0);

        for (int p = 0; p < 9; p++)
        begin
            settle_block();
            idle_pct = (p < 3) ? 28 : ((p < 6) ? 51 : 0);
            apply_settings(4'(settings_count[p]), 3'(settings_primary[p]));
            goal = queued_total + 34;
            while (queued_total < goal)
            begin
                queue_scenario(live_slots());
                if ($urandom_range(0, 9) == 0)
                begin
                    drain_results();
                end
            end
        end
        settle_block();

        $display("covered %0d loads and %0d resizes under %0d register settings",
                 loads_sent, resizes_sent, settings_applied);
        $display("%0d adjusted rectangles checked, %0d mismatches",
                 results_checked, error_count);
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
